FILE: src/msort_pkg.sv
// shared constants, types and helpers for the merge sorter
// no dependencies; used by msort_store and merge_sorter_unit
package msort_pkg;

  localparam int DEPTH  = 32;
  localparam int DATA_W = 32;
  localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int SUM_W  = CNT_W + 2;

  typedef logic [DATA_W-1:0] data_t;
  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [SUM_W-1:0]  sum_t;

  // one request to the two-bank store
  typedef struct packed {
    logic  we;
    logic  wbank;
    idx_t  waddr;
    data_t wdata;
    logic  re;
    logic  rbank;
    idx_t  raddr_i;
    idx_t  raddr_j;
  } mem_req_t;

  // run boundary clipped to the set size
  function automatic cnt_t clip_to(input sum_t a, input cnt_t n);
    cnt_t r;
    if (a > {2'b00, n}) begin
      r = n;
    end else begin
      r = a[CNT_W-1:0];
    end
    return r;
  endfunction

endpackage

FILE: src/msort_store.sv
// two-bank value store for the merge sorter: one write port, two registered reads
// depends on msort_pkg
module msort_store (
  input  logic                clk,
  input  msort_pkg::mem_req_t req,
  output msort_pkg::data_t    rd_i,
  output msort_pkg::data_t    rd_j
);

  msort_pkg::data_t mem_a [msort_pkg::DEPTH];
  msort_pkg::data_t mem_b [msort_pkg::DEPTH];
  msort_pkg::data_t a_i, a_j, b_i, b_j;
  logic             bank_q;

  always_ff @(posedge clk) begin
    if (req.we && !req.wbank) begin
      mem_a[req.waddr] <= req.wdata;
    end
    if (req.we && req.wbank) begin
      mem_b[req.waddr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      a_i    <= mem_a[req.raddr_i];
      a_j    <= mem_a[req.raddr_j];
      b_i    <= mem_b[req.raddr_i];
      b_j    <= mem_b[req.raddr_j];
      bank_q <= req.rbank;
    end
  end

  assign rd_i = bank_q ? b_i : a_i;
  assign rd_j = bank_q ? b_j : a_j;

endmodule

FILE: src/merge_sorter_unit.sv
// merge sorter top level: load, bottom-up merge passes, sorted output
// depends on msort_pkg and msort_store
//
// Collects signed 32-bit values, one per request, until a request with tlast
// arrives or 32 values are held (that request then ends the set). The set is
// then sorted ascending with a stable bottom-up merge sort and streamed out,
// tlast marking the greatest value. While loading, a value is taken
// whenever one is offered. The sort runs ceil(log2 n) passes that
// ping-pong between two store banks; one shared signed compare picks
// each value in two steps: read both run heads, then compare and write
// the winner. Each output value is read, then presented downstream until
// it is taken. The single compare unit and the store's one write per
// cycle bound the sort speed. No new request is taken from sort start
// until the last sorted value has left.
module merge_sorter_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] sample_value
  input  logic        s_tlast,   // last_item
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] sorted_value
  output logic        m_tlast    // final_item
);

  localparam logic [2:0] ST_LOAD = 3'd0;  // taking values
  localparam logic [2:0] ST_RD   = 3'd1;  // read both run heads
  localparam logic [2:0] ST_MRG  = 3'd2;  // compare, write winner
  localparam logic [2:0] ST_ERD  = 3'd3;  // read next sorted value
  localparam logic [2:0] ST_EOUT = 3'd4;  // present it downstream

  logic [2:0]        state;
  msort_pkg::cnt_t   cnt;      // values held in the current set
  msort_pkg::cnt_t   n;        // size of the set being sorted
  msort_pkg::cnt_t   w;        // current run width
  msort_pkg::cnt_t   i, j, k;  // left head, right head, output index
  msort_pkg::cnt_t   mid, hi;  // end of left run, end of right run
  logic              src;      // bank holding the current runs

  msort_pkg::mem_req_t req;
  msort_pkg::data_t    rd_i, rd_j;

  logic              in_ok, out_ok, set_end, take_i;
  msort_pkg::cnt_t   cnt_inc, k_inc;
  msort_pkg::sum_t   w2, hi_w, hi_2w;

  assign s_tready = (state == ST_LOAD);
  assign m_tvalid = (state == ST_EOUT);
  assign m_tdata  = rd_i;
  assign m_tlast  = (k_inc == n);

  assign in_ok   = s_tvalid && s_tready;
  assign out_ok  = m_tvalid && m_tready;
  assign cnt_inc = cnt + 1'b1;
  assign k_inc   = k + 1'b1;
  assign set_end = s_tlast || (cnt_inc == msort_pkg::CNT_W'(msort_pkg::DEPTH));

  // shared compare: left wins on ties to keep arrival order
  assign take_i = (j >= hi) || ((i < mid) && ($signed(rd_i) <= $signed(rd_j)));

  assign w2    = {1'b0, w, 1'b0};
  assign hi_w  = {2'b00, hi} + {2'b00, w};
  assign hi_2w = {2'b00, hi} + w2;

  // store requests
  always_comb begin
    req         = '0;
    req.rbank   = src;
    req.raddr_i = i[msort_pkg::IDX_W-1:0];
    req.raddr_j = j[msort_pkg::IDX_W-1:0];
    unique case (state)
      ST_LOAD: begin
        req.we    = in_ok;
        req.wbank = 1'b0;
        req.waddr = cnt[msort_pkg::IDX_W-1:0];
        req.wdata = s_tdata;
      end
      ST_RD: begin
        req.re = 1'b1;
      end
      ST_MRG: begin
        req.we    = 1'b1;
        req.wbank = ~src;
        req.waddr = k[msort_pkg::IDX_W-1:0];
        req.wdata = take_i ? rd_i : rd_j;
      end
      ST_ERD: begin
        req.re      = 1'b1;
        req.raddr_i = k[msort_pkg::IDX_W-1:0];
      end
      default: begin
      end
    endcase
  end

  msort_store u_store (
    .clk  (clk),
    .req  (req),
    .rd_i (rd_i),
    .rd_j (rd_j)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
      cnt   <= '0;
      n     <= '0;
      k     <= '0;
    end else begin
      unique case (state)
        ST_LOAD: begin
          if (in_ok) begin
            cnt <= cnt_inc;
            if (set_end) begin
              n   <= cnt_inc;
              src <= 1'b0;
              k   <= '0;
              w   <= msort_pkg::CNT_W'(1);
              i   <= '0;
              if (cnt == '0) begin
                // single value: nothing to merge
                state <= ST_ERD;
              end else begin
                mid   <= msort_pkg::CNT_W'(1);
                j     <= msort_pkg::CNT_W'(1);
                hi    <= msort_pkg::clip_to(msort_pkg::SUM_W'(2), cnt_inc);
                state <= ST_RD;
              end
            end
          end
        end
        ST_RD: begin
          state <= ST_MRG;
        end
        ST_MRG: begin
          if (k_inc != hi) begin
            // still inside the current pair of runs
            if (take_i) begin
              i <= i + 1'b1;
            end else begin
              j <= j + 1'b1;
            end
            k     <= k_inc;
            state <= ST_RD;
          end else if (hi != n) begin
            // next pair of runs in this pass
            k     <= k_inc;
            i     <= hi;
            mid   <= msort_pkg::clip_to(hi_w, n);
            j     <= msort_pkg::clip_to(hi_w, n);
            hi    <= msort_pkg::clip_to(hi_2w, n);
            state <= ST_RD;
          end else begin
            // pass complete: results now live in the other bank
            src <= ~src;
            k   <= '0;
            if (w2 >= {2'b00, n}) begin
              state <= ST_ERD;
            end else begin
              w     <= w2[msort_pkg::CNT_W-1:0];
              i     <= '0;
              mid   <= msort_pkg::clip_to(w2, n);
              j     <= msort_pkg::clip_to(w2, n);
              hi    <= msort_pkg::clip_to({w2[msort_pkg::SUM_W-2:0], 1'b0}, n);
              state <= ST_RD;
            end
          end
        end
        ST_ERD: begin
          state <= ST_EOUT;
        end
        ST_EOUT: begin
          if (out_ok) begin
            if (k_inc == n) begin
              cnt   <= '0;
              state <= ST_LOAD;
            end else begin
              k     <= k_inc;
              state <= ST_ERD;
            end
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
  end

  // load and output never overlap
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("input and output active together");

  // merge never writes past the set
  a_k_in_set: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MRG) |-> (k < n))
    else $error("merge index beyond set size");

  // run heads stay inside their runs
  a_heads: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MRG) |-> ((i <= mid) && (j <= hi) && (mid <= hi) && (hi <= n)))
    else $error("run heads out of bounds");

  // after the final value leaves, loading resumes
  a_back_to_load: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && m_tlast) |=> (s_tready && (cnt == '0)))
    else $error("did not return to loading");

endmodule

FILE: tb/testbench.sv
// self-checking bench for merge_sorter_unit: random and directed value sets
// depends on msort_pkg (DEPTH, data_t) and the merge_sorter_unit rtl
module testbench;

  // one request offered on the input side
  typedef struct {
    msort_pkg::data_t value;
    logic  last;
    logic  drain;  // hold this request back until all sorted output has come
  } sample_t;

  // one sorted value awaited on the output side
  typedef struct {
    msort_pkg::data_t value;
    logic  tail_mark;
  } sorted_t;

  localparam int HOLD_AT     = 100;  // result count at which the long output stall starts
  localparam int HOLD_CYCLES = 400;
  localparam int SEND_QUIET_LO = 200, SEND_QUIET_HI = 280;
  localparam int RECV_QUIET_LO = 250, RECV_QUIET_HI = 330;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;   // [31:0] sample_value
  logic        s_tlast = 1'b0; // last_item
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;        // [31:0] sorted_value
  logic        m_tlast;        // final_item

  sample_t          sample_q[$];
  sorted_t          sorted_expect_q[$];
  msort_pkg::data_t open_set[$];
  sample_t          shown;
  int      sent_count = 0;
  int      result_count = 0;
  int      errors = 0;
  int      hold_left = 0;
  bit      hold_done = 1'b0;

  merge_sorter_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always #4 clk = ~clk;

  // add one accepted value to the open set; when the set closes, sort it
  // stably (insertion sort keeps equal values in arrival order) and queue
  // every value as an awaited result
  task automatic sort_and_queue(input sample_t s);
    msort_pkg::data_t arr[$];
    msort_pkg::data_t key;
    sorted_t r;
    int      j;
    open_set.push_back(s.value);
    if (s.last || open_set.size() >= msort_pkg::DEPTH) begin
      arr = open_set;
      for (int i = 1; i < arr.size(); i++) begin
        key = arr[i];
        j = i - 1;
        while (j >= 0 && $signed(arr[j]) > $signed(key)) begin
          arr[j+1] = arr[j];
          j--;
        end
        arr[j+1] = key;
      end
      foreach (arr[k]) begin
        r.value = arr[k];
        r.tail_mark = (k == arr.size() - 1);
        sorted_expect_q.push_back(r);
      end
      open_set.delete();
    end
  endtask

  function automatic msort_pkg::data_t pick_value(input int mode);
    msort_pkg::data_t edges[6];
    msort_pkg::data_t v;
    edges = '{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000,
              32'hffff_ffff, 32'h0000_0001, 32'h8000_0001};
    case (mode)
      0: v = $urandom;
      1: v = msort_pkg::data_t'(int'($urandom_range(0, 6)) - 3);  // many duplicates
      2: v = edges[$urandom_range(0, 5)];
      default: v = {1'($urandom_range(0, 1)), 31'($urandom)};
    endcase
    return v;
  endfunction

  // sender: one request held until accepted, then the next one from the
  // pending queue; random gaps, a gap-free window, and a full drain pause
  always @(posedge clk) begin
    bit gap;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        sort_and_queue(shown);
        sent_count++;
      end
      if (!(s_tvalid && !s_tready)) begin
        gap = (sample_q.size() == 0);
        if (!gap && sample_q[0].drain && sorted_expect_q.size() != 0) gap = 1'b1;
        if (!gap && !(sent_count >= SEND_QUIET_LO && sent_count < SEND_QUIET_HI))
          gap = ($urandom_range(0, 99) < 8);
        if (gap) begin
          s_tvalid <= 1'b0;
        end else begin
          shown = sample_q.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= shown.value;
          s_tlast  <= shown.last;
        end
      end
    end
  end

  // receiver: compare each accepted result with the oldest awaited one
  always @(posedge clk) begin
    sorted_t want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        result_count++;
        if (sorted_expect_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual value %h last %b",
                   $time, m_tdata, m_tlast);
          errors++;
        end else begin
          want = sorted_expect_q.pop_front();
          if (m_tdata !== want.value) begin
            $display("%0t: sorted_value mismatch, expected %h, actual %h",
                     $time, want.value, m_tdata);
            errors++;
          end
          if (m_tlast !== want.tail_mark) begin
            $display("%0t: final_item mismatch, expected %b, actual %b",
                     $time, want.tail_mark, m_tlast);
            errors++;
          end
        end
      end
      // long output stall so the block backs up while the sender keeps offering
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (!hold_done && result_count >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        m_tready <= 1'b0;
      end else if (result_count >= RECV_QUIET_LO && result_count < RECV_QUIET_HI) begin
        m_tready <= 1'b1;
      end else begin
        m_tready <= ($urandom_range(0, 99) >= 8);
      end
    end
  end

  task automatic add_sample(input msort_pkg::data_t v, input logic last, input logic drain);
    sample_t s;
    s.value = v;
    s.last  = last;
    s.drain = drain;
    sample_q.push_back(s);
  endtask

  // stimulus and end of run
  initial begin
    int    size, mode, set_idx, total;
    logic  close;
    // single-value set at the most negative value
    add_sample(32'h8000_0000, 1'b1, 1'b0);
    // extremes in mixed order
    add_sample(32'h7fff_ffff, 1'b0, 1'b0);
    add_sample(32'h8000_0000, 1'b0, 1'b0);
    add_sample(32'h0000_0000, 1'b0, 1'b0);
    add_sample(32'hffff_ffff, 1'b0, 1'b0);
    add_sample(32'h0000_0001, 1'b0, 1'b0);
    add_sample(32'h8000_0001, 1'b1, 1'b0);
    // duplicates, after a full drain
    add_sample(32'd5, 1'b0, 1'b1);
    add_sample(32'd5, 1'b0, 1'b0);
    add_sample(-32'sd5, 1'b0, 1'b0);
    add_sample(32'd5, 1'b0, 1'b0);
    add_sample(-32'sd5, 1'b1, 1'b0);
    // strictly descending
    for (int k = 0; k < 8; k++) add_sample(msort_pkg::data_t'(100 - 30 * k), k == 7, 1'b0);
    total = sample_q.size();
    set_idx = 0;
    // random sets: mostly small, some full ones closed by the store limit
    while (total < 400) begin
      case ($urandom_range(0, 9))
        0, 1: size = msort_pkg::DEPTH;
        2:    size = msort_pkg::DEPTH - 1;
        default: size = $urandom_range(1, 12);
      endcase
      mode = $urandom_range(0, 3);
      close = $urandom_range(0, 1);
      for (int k = 0; k < size; k++)
        add_sample(pick_value(mode),
                   (k == size - 1) && (size < msort_pkg::DEPTH || close),
                   (k == 0) && (set_idx == 12));
      total += size;
      set_idx++;
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while (sample_q.size() != 0 || s_tvalid) @(posedge clk);
    while (sorted_expect_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (errors == 0 && sorted_expect_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(8 * 300000);
    $display("FAILED: results differ");
    $finish;
  end

endmodule
